// File: hdl/i2cms_pkg.sv
`default_nettype none
package i2cms_pkg;

  localparam int unsigned CNT_W = 5;
  localparam int unsigned IDX_W = 4;
  localparam logic [CNT_W-1:0] MAX_LEN = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

  localparam logic [7:0] ST_MASK      = 8'b1111_1000;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_REP_START = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_DTX_ACK   = 8'h28;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_DRX_ACK   = 8'h50;
  localparam logic [7:0] ST_DRX_NACK  = 8'h58;

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_TX      = 3'd3,
    CMD_RX_ACK  = 3'd4,
    CMD_RX_NACK = 3'd5
  } cmd_t;

  typedef struct packed {
    logic             opcode;
    logic [7:0]       bus_status;
    logic [7:0]       rx_byte;
    logic             queue_nonempty;
    logic [6:0]       target_address;
    logic             read_request;
    logic [CNT_W-1:0] transfer_length;
  } in_item_t;

  typedef struct packed {
    cmd_t             bus_command;
    logic             tx_from_buffer;
    logic [7:0]       address_byte;
    logic [IDX_W-1:0] buffer_index;
    logic             store_enable;
    logic [7:0]       store_byte;
    logic             advance_queue;
    logic             busy_res;
  } out_item_t;

endpackage
`default_nettype wire

// File: hdl/i2cms_if.sv
`default_nettype none
interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] bus_status;
  logic [7:0] rx_byte;
  logic       queue_nonempty;
  logic [6:0] target_address;
  logic       read_request;
  logic [4:0] transfer_length;

  modport source (output valid, opcode, bus_status, rx_byte, queue_nonempty,
                  target_address, read_request, transfer_length, input ready);
  modport sink (input valid, opcode, bus_status, rx_byte, queue_nonempty,
                target_address, read_request, transfer_length, output ready);
endinterface

interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_command;
  logic       tx_from_buffer;
  logic [7:0] address_byte;
  logic [3:0] buffer_index;
  logic       store_enable;
  logic [7:0] store_byte;
  logic       advance_queue;
  logic       busy_res;

  modport source (output valid, bus_command, tx_from_buffer, address_byte,
                  buffer_index, store_enable, store_byte, advance_queue, busy_res,
                  input ready);
  modport sink (input valid, bus_command, tx_from_buffer, address_byte,
                buffer_index, store_enable, store_byte, advance_queue, busy_res,
                output ready);
endinterface
`default_nettype wire

// File: hdl/i2c_master_transfer_sequencer_unit.sv
// I2C master transfer sequencer: each input item (a poll or a bus status event,
// AVR TWI status codes) yields exactly one result item carrying the next bus
// command, address byte or buffer index, store request and queue advance flag.
// Each item is held in the input register, then decoded into the result register,
// and one item is taken every cycle; throughput is limited only by the sink's ready.
`default_nettype none
module i2c_master_transfer_sequencer_unit
  import i2cms_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  i2cms_in_if.sink    item_in,
  i2cms_out_if.source item_out
);

  in_item_t  up_item, st_item;
  out_item_t st_res, out_item;
  logic      st_valid, out_free, fire;

  assign up_item = '{
    opcode:          item_in.opcode,
    bus_status:      item_in.bus_status,
    rx_byte:         item_in.rx_byte,
    queue_nonempty:  item_in.queue_nonempty,
    target_address:  item_in.target_address,
    read_request:    item_in.read_request,
    transfer_length: item_in.transfer_length
  };

  assign fire = st_valid && out_free;

  i2cms_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .up_valid (item_in.valid),
    .up_ready (item_in.ready),
    .up_item  (up_item),
    .dn_valid (st_valid),
    .dn_take  (out_free),
    .dn_item  (st_item)
  );

  i2cms_step u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (st_item),
    .res  (st_res)
  );

  i2cms_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .free     (out_free),
    .res      (st_res),
    .dn_valid (item_out.valid),
    .dn_ready (item_out.ready),
    .dn_item  (out_item)
  );

  assign item_out.bus_command    = out_item.bus_command;
  assign item_out.tx_from_buffer = out_item.tx_from_buffer;
  assign item_out.address_byte   = out_item.address_byte;
  assign item_out.buffer_index   = out_item.buffer_index;
  assign item_out.store_enable   = out_item.store_enable;
  assign item_out.store_byte     = out_item.store_byte;
  assign item_out.advance_queue  = out_item.advance_queue;
  assign item_out.busy_res       = out_item.busy_res;

endmodule
`default_nettype wire

// File: hdl/i2cms_in_stage.sv
`default_nettype none
module i2cms_in_stage
  import i2cms_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     up_valid,
  output logic          up_ready,
  input  wire in_item_t up_item,
  output logic          dn_valid,
  input  wire logic     dn_take,
  output in_item_t      dn_item
);

  logic valid;
  in_item_t item;

  assign up_ready = !valid || dn_take;
  assign dn_valid = valid;
  assign dn_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      item <= up_item;
    end
  end

endmodule
`default_nettype wire

// File: hdl/i2cms_step.sv
`default_nettype none
module i2cms_step
  import i2cms_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     fire,
  input  wire in_item_t item,
  output out_item_t     res
);

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic             active_flag, active_flag_next;

  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       status;
  logic             finish;
  logic             can_store;

  function automatic cmd_t rx_cmd(input logic [CNT_W-1:0] c, input logic [CNT_W-1:0] l);
    logic [CNT_W:0] c1;
    c1 = {1'b0, c} + {{CNT_W{1'b0}}, 1'b1};
    return (c1 >= {1'b0, l}) ? CMD_RX_NACK : CMD_RX_ACK;
  endfunction

  assign len       = (item.transfer_length > MAX_LEN) ? MAX_LEN : item.transfer_length;
  assign cnt_inc   = (byte_count == CNT_MAX) ? CNT_MAX : byte_count + CNT_W'(1);
  assign status    = item.bus_status & ST_MASK;
  assign can_store = byte_count < MAX_LEN;

  always_comb begin
    res = '0;
    res.bus_command = CMD_NONE;
    finish = 1'b0;
    byte_count_next = byte_count;
    active_flag_next = active_flag;
    if (item.opcode == OP_POLL) begin
      if (!active_flag && item.queue_nonempty) begin
        res.bus_command = CMD_START;
        active_flag_next = 1'b1;
      end
    end else if (item.queue_nonempty) begin
      case (status)
        ST_START, ST_REP_START: begin
          res.bus_command  = CMD_TX;
          res.address_byte = {item.target_address, item.read_request};
        end
        ST_SLAW_ACK: begin
          res.bus_command    = CMD_TX;
          res.tx_from_buffer = 1'b1;
          byte_count_next    = 5'd1;
        end
        ST_DTX_ACK: begin
          if (byte_count >= len) begin
            finish = 1'b1;
          end else begin
            res.bus_command    = CMD_TX;
            res.tx_from_buffer = 1'b1;
            res.buffer_index   = byte_count[IDX_W-1:0];
            byte_count_next    = cnt_inc;
          end
        end
        ST_SLAR_ACK: begin
          res.bus_command = rx_cmd(byte_count, len);
        end
        ST_DRX_ACK: begin
          if (can_store) begin
            res.store_enable = 1'b1;
            res.store_byte   = item.rx_byte;
            res.buffer_index = byte_count[IDX_W-1:0];
          end
          byte_count_next = cnt_inc;
          res.bus_command = rx_cmd(cnt_inc, len);
        end
        ST_DRX_NACK: begin
          if (can_store) begin
            res.store_enable = 1'b1;
            res.store_byte   = item.rx_byte;
            res.buffer_index = byte_count[IDX_W-1:0];
          end
          finish = 1'b1;
        end
        default: begin
          finish = 1'b1;
        end
      endcase
      if (finish) begin
        res.bus_command   = CMD_STOP;
        res.advance_queue = 1'b1;
        byte_count_next   = '0;
        active_flag_next  = 1'b0;
      end else begin
        active_flag_next = 1'b1;
      end
    end
    res.busy_res = active_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      active_flag <= 1'b0;
    end else if (fire) begin
      byte_count  <= byte_count_next;
      active_flag <= active_flag_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/i2cms_out_stage.sv
`default_nettype none
module i2cms_out_stage
  import i2cms_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  output logic           free,
  input  wire out_item_t res,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output out_item_t      dn_item
);

  logic valid;
  out_item_t item;

  assign free     = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
    if (load) begin
      item <= res;
    end
  end

endmodule
`default_nettype wire

// File: hdl/i2cms_checker.sv
`default_nettype none
module i2cms_checker
  import i2cms_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       valid,
  input wire logic       ready,
  input wire logic [2:0] bus_command,
  input wire logic       tx_from_buffer,
  input wire logic [7:0] address_byte,
  input wire logic       store_enable,
  input wire logic       advance_queue,
  input wire logic       busy_res
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(bus_command) && $stable(busy_res))
    else $error("stalled item changed");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    valid && advance_queue |-> bus_command == CMD_STOP && !busy_res)
    else $error("advance without stop or still busy");

  a_store: assert property (@(posedge clk) disable iff (rst)
    valid && store_enable |->
      bus_command == CMD_RX_ACK || bus_command == CMD_RX_NACK || bus_command == CMD_STOP)
    else $error("store without receive or stop");

  a_tx_buf: assert property (@(posedge clk) disable iff (rst)
    valid && tx_from_buffer |-> bus_command == CMD_TX && address_byte == 8'd0 && busy_res)
    else $error("buffer transmit inconsistent");

endmodule

bind i2c_master_transfer_sequencer_unit i2cms_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .valid          (item_out.valid),
  .ready          (item_out.ready),
  .bus_command    (item_out.bus_command),
  .tx_from_buffer (item_out.tx_from_buffer),
  .address_byte   (item_out.address_byte),
  .store_enable   (item_out.store_enable),
  .advance_queue  (item_out.advance_queue),
  .busy_res       (item_out.busy_res)
);
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import i2cms_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  // status codes the block treats as faults
  localparam logic [7:0] ST_BUS_ERROR = 8'h00;
  localparam logic [7:0] ST_SLAW_NACK = 8'h20;
  localparam logic [7:0] ST_DTX_NACK  = 8'h30;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_SLAR_NACK = 8'h48;
  localparam logic [7:0] ST_NO_INFO   = 8'hF8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   errors = 0;
  int   items_sent = 0;

  bit src_gaps = 1'b0;
  bit sink_gaps = 1'b0;
  int sink_hold = 0;

  // current instruction and transfer shaping
  in_item_t instr;
  int       step_no;
  int       abort_at = -1;
  bit       jitter_on = 1'b0;

  // predictor state
  logic [CNT_W-1:0] txn_count = '0;
  logic             txn_busy = 1'b0;

  out_item_t expected_actions[$];

  i2cms_in_if  in_ch ();
  i2cms_out_if out_ch ();

  i2c_master_transfer_sequencer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .item_in  (in_ch),
    .item_out (out_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("i2c_master_transfer_sequencer_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [CNT_W-1:0] bumped(input logic [CNT_W-1:0] cnt);
    return (cnt >= CNT_MAX) ? CNT_MAX : cnt + CNT_W'(1);
  endfunction

  function automatic cmd_t receive_command(input logic [CNT_W-1:0] cnt,
                                           input logic [CNT_W-1:0] len);
    return ({1'b0, cnt} + 6'd1 >= {1'b0, len}) ? CMD_RX_NACK : CMD_RX_ACK;
  endfunction

  function automatic out_item_t next_bus_action(input in_item_t it);
    out_item_t        r;
    logic [7:0]       st;
    logic [CNT_W-1:0] len;
    logic             done;
    r = '0;
    st = it.bus_status & ST_MASK;
    len = (it.transfer_length > MAX_LEN) ? MAX_LEN : it.transfer_length;
    done = 1'b0;
    if (it.opcode == OP_POLL) begin
      if (!txn_busy && it.queue_nonempty) begin
        r.bus_command = CMD_START;
        txn_busy = 1'b1;
      end
    end else if (it.queue_nonempty) begin
      case (st)
        ST_START, ST_REP_START: begin
          r.bus_command = CMD_TX;
          r.address_byte = {it.target_address, it.read_request};
        end
        ST_SLAW_ACK: begin
          r.bus_command = CMD_TX;
          r.tx_from_buffer = 1'b1;
          txn_count = 5'd1;
        end
        ST_DTX_ACK: begin
          if (txn_count >= len) begin
            done = 1'b1;
          end else begin
            r.bus_command = CMD_TX;
            r.tx_from_buffer = 1'b1;
            r.buffer_index = txn_count[IDX_W-1:0];
            txn_count = bumped(txn_count);
          end
        end
        ST_SLAR_ACK: r.bus_command = receive_command(txn_count, len);
        ST_DRX_ACK: begin
          if (txn_count < MAX_LEN) begin
            r.store_enable = 1'b1;
            r.store_byte = it.rx_byte;
            r.buffer_index = txn_count[IDX_W-1:0];
          end
          txn_count = bumped(txn_count);
          r.bus_command = receive_command(txn_count, len);
        end
        ST_DRX_NACK: begin
          if (txn_count < MAX_LEN) begin
            r.store_enable = 1'b1;
            r.store_byte = it.rx_byte;
            r.buffer_index = txn_count[IDX_W-1:0];
          end
          done = 1'b1;
        end
        default: done = 1'b1;
      endcase
      if (done) begin
        r.bus_command = CMD_STOP;
        r.advance_queue = 1'b1;
        txn_count = '0;
        txn_busy = 1'b0;
      end else begin
        txn_busy = 1'b1;
      end
    end
    r.busy_res = txn_busy;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_actions.size() == 0) begin
        $error("result item with no pending expectation");
        errors++;
      end else begin
        want = expected_actions.pop_front();
        check_field("bus_command", 8'(want.bus_command), 8'(out_ch.bus_command));
        check_field("tx_from_buffer", 8'(want.tx_from_buffer), 8'(out_ch.tx_from_buffer));
        check_field("address_byte", want.address_byte, out_ch.address_byte);
        check_field("buffer_index", 8'(want.buffer_index), 8'(out_ch.buffer_index));
        check_field("store_enable", 8'(want.store_enable), 8'(out_ch.store_enable));
        check_field("store_byte", want.store_byte, out_ch.store_byte);
        check_field("advance_queue", 8'(want.advance_queue), 8'(out_ch.advance_queue));
        check_field("busy_res", 8'(want.busy_res), 8'(out_ch.busy_res));
      end
    end
  end

  // result receiver: random stalls, plus a long hold when requested
  initial begin : receiver
    int gap;
    out_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = 0;
      if (sink_hold > 0) begin
        gap = sink_hold;
        sink_hold = 0;
      end else if (sink_gaps) begin
        gap = $urandom_range(0, 11);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_item(input in_item_t it, output out_item_t predicted);
    int gap;
    gap = src_gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.opcode          <= it.opcode;
    in_ch.bus_status      <= it.bus_status;
    in_ch.rx_byte         <= it.rx_byte;
    in_ch.queue_nonempty  <= it.queue_nonempty;
    in_ch.target_address  <= it.target_address;
    in_ch.read_request    <= it.read_request;
    in_ch.transfer_length <= it.transfer_length;
    do @(posedge clk); while (!in_ch.ready);
    predicted = next_bus_action(it);
    expected_actions.push_back(predicted);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CNT_W-1:0] pick_length();
    if ($urandom_range(0, 99) < 75) return 5'($urandom_range(0, 16));
    return 5'($urandom_range(17, 31));
  endfunction

  function automatic logic [7:0] fault_status();
    case ($urandom_range(0, 6))
      0: return ST_BUS_ERROR;
      1: return ST_SLAW_NACK;
      2: return ST_DTX_NACK;
      3: return ST_ARB_LOST;
      4: return ST_SLAR_NACK;
      5: return ST_NO_INFO;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] any_status();
    case ($urandom_range(0, 9))
      0: return ST_START;
      1: return ST_REP_START;
      2: return ST_SLAW_ACK;
      3: return ST_DTX_ACK;
      4: return ST_SLAR_ACK;
      5: return ST_DRX_ACK;
      6: return ST_DRX_NACK;
      7: return fault_status();
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic set_instr(input logic [6:0] addr, input logic rd,
                           input logic [CNT_W-1:0] len, input logic qne);
    instr.target_address = addr;
    instr.read_request = rd;
    instr.transfer_length = len;
    instr.queue_nonempty = qne;
  endtask

  task automatic send_event(input logic [7:0] status, input logic [7:0] rx,
                            output out_item_t r);
    in_item_t it;
    step_no++;
    if (jitter_on && $urandom_range(0, 15) == 0) instr.transfer_length = pick_length();
    it = instr;
    it.opcode = OP_EVENT;
    it.bus_status = ((step_no == abort_at) ? fault_status() : status)
                    | 8'($urandom_range(0, 7));
    it.rx_byte = rx;
    send_item(it, r);
  endtask

  task automatic send_poll(output out_item_t r);
    in_item_t it;
    it = instr;
    it.opcode = OP_POLL;
    it.bus_status = 8'($urandom);
    it.rx_byte = 8'($urandom);
    send_item(it, r);
  endtask

  task automatic send_noise();
    in_item_t  it;
    out_item_t r;
    it.opcode = 1'($urandom);
    it.bus_status = any_status() | 8'($urandom_range(0, 7));
    it.rx_byte = 8'($urandom);
    it.queue_nonempty = ($urandom_range(0, 3) != 0);
    it.target_address = 7'($urandom);
    it.read_request = 1'($urandom);
    it.transfer_length = 5'($urandom);
    send_item(it, r);
  endtask

  // one well-formed transfer with random content, sometimes broken off
  task automatic run_transfer();
    out_item_t r;
    int        overrun;
    int        n;
    set_instr(7'($urandom), 1'($urandom), pick_length(), 1'b1);
    step_no = 0;
    abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : -1;
    jitter_on = ($urandom_range(0, 7) == 0);
    overrun = ($urandom_range(0, 11) == 0) ? $urandom_range(17, 40) : 0;
    send_poll(r);
    send_event($urandom_range(0, 3) == 0 ? ST_REP_START : ST_START, 8'($urandom), r);
    n = 0;
    if (!instr.read_request) begin
      send_event(ST_SLAW_ACK, 8'($urandom), r);
      while (txn_busy && n < 40) begin
        send_event(ST_DTX_ACK, 8'($urandom), r);
        n++;
      end
    end else begin
      send_event(ST_SLAR_ACK, 8'($urandom), r);
      while (txn_busy && n < 45 && (r.bus_command == CMD_RX_ACK || n < overrun)) begin
        send_event(ST_DRX_ACK, 8'($urandom), r);
        n++;
      end
      if (txn_busy) send_event(ST_DRX_NACK, 8'($urandom), r);
    end
    abort_at = -1;
    jitter_on = 1'b0;
  endtask

  task automatic pick_idling();
    src_gaps = ($urandom_range(0, 2) != 0);
    sink_gaps = ($urandom_range(0, 2) != 0);
  endtask

  task automatic test_directed();
    out_item_t r;
    abort_at = -1;
    jitter_on = 1'b0;
    // empty queue: event and poll do nothing
    set_instr(7'h7F, 1'b0, 5'd2, 1'b0);
    send_event(ST_START, 8'h12, r);
    send_poll(r);
    // write of two bytes to the top address, poll while busy
    instr.queue_nonempty = 1'b1;
    send_poll(r);
    send_poll(r);
    send_event(ST_START, 8'hFF, r);
    send_event(ST_SLAW_ACK, 8'h00, r);
    send_event(ST_DTX_ACK, 8'h34, r);
    send_event(ST_DTX_ACK, 8'h56, r);
    // zero-length read from address zero
    set_instr(7'h00, 1'b1, 5'd0, 1'b1);
    send_poll(r);
    send_event(ST_REP_START, 8'h00, r);
    send_event(ST_SLAR_ACK, 8'h00, r);
    send_event(ST_DRX_NACK, 8'hFF, r);
    // clamped length, then length lowered mid-transfer
    set_instr(7'h55, 1'b1, 5'd31, 1'b1);
    send_poll(r);
    send_event(ST_START, 8'h77, r);
    send_event(ST_SLAR_ACK, 8'h77, r);
    send_event(ST_DRX_ACK, 8'h00, r);
    instr.transfer_length = 5'd2;
    send_event(ST_DRX_ACK, 8'hA5, r);
    set_instr(7'h2A, 1'b0, 5'd1, 1'b1);
    send_event(ST_DTX_ACK, 8'h5A, r);
    // events while idle, slave NACK, unknown status
    send_event(ST_SLAW_ACK, 8'hC3, r);
    send_event(ST_SLAW_NACK, 8'h3C, r);
    send_event(ST_NO_INFO, 8'h81, r);
    instr.queue_nonempty = 1'b0;
    send_event(ST_DRX_ACK, 8'h7E, r);
    instr.queue_nonempty = 1'b1;
    send_poll(r);
    send_event(ST_BUS_ERROR, 8'h18, r);
  endtask

  task automatic test_random_traffic(input int count);
    int first;
    first = items_sent;
    while (items_sent - first < count) begin
      if ($urandom_range(0, 7) == 0) pick_idling();
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) send_noise();
      else run_transfer();
    end
  endtask

  // receiver holds off while the sender streams, so the block backs up
  task automatic test_output_stall();
    int first;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    sink_hold = 60;
    first = items_sent;
    while (items_sent - first < 90) run_transfer();
  endtask

  task automatic test_drain_pause();
    pick_idling();
    repeat (3) run_transfer();
    wait_drained();
    repeat (3) run_transfer();
  endtask

  initial begin
    in_ch.valid           <= 1'b0;
    in_ch.opcode          <= OP_EVENT;
    in_ch.bus_status      <= '0;
    in_ch.rx_byte         <= '0;
    in_ch.queue_nonempty  <= 1'b0;
    in_ch.target_address  <= '0;
    in_ch.read_request    <= 1'b0;
    in_ch.transfer_length <= '0;
    instr = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    pick_idling();
    test_random_traffic(750);
    test_output_stall();
    test_drain_pause();
    test_random_traffic(750);

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("i2c_master_transfer_sequencer_unit regression: pass");
    end else begin
      $display("i2c_master_transfer_sequencer_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/i2cms_pkg.sv
hdl/i2cms_if.sv
hdl/i2cms_in_stage.sv
hdl/i2cms_step.sv
hdl/i2cms_out_stage.sv
hdl/i2c_master_transfer_sequencer_unit.sv
hdl/i2cms_checker.sv
bench/testbench.sv
